// ----- rtl/sha1he_pkg.sv -----
`default_nettype none

package sha1he_pkg;

    localparam int unsigned BLK_BITS  = 512;
    localparam int unsigned NUM_ROUND = 80;
    localparam int unsigned CNT_W     = 61;  // byte count; bit length is this times 8 mod 2^64

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [6:0] RND_LAST = 7'(NUM_ROUND - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sha1he_round.sv -----
`default_nettype none

module sha1he_round (
    input  wire sha1he_pkg::t_vars i_vars,
    input  wire logic [31:0]       i_w,
    input  wire logic [6:0]        i_rnd,
    output sha1he_pkg::t_vars      o_vars
);
    import sha1he_pkg::*;

    logic [31:0] v_f;
    logic [31:0] v_k;
    logic [31:0] v_tmp;

    always_comb begin
        if (i_rnd < 7'd20) begin
            v_f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            v_k = K_R0;
        end else if (i_rnd < 7'd40) begin
            v_f = i_vars.b ^ i_vars.c ^ i_vars.d;
            v_k = K_R1;
        end else if (i_rnd < 7'd60) begin
            v_f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            v_k = K_R2;
        end else begin
            v_f = i_vars.b ^ i_vars.c ^ i_vars.d;
            v_k = K_R3;
        end
        v_tmp    = rotl5(i_vars.a) + v_f + i_vars.e + v_k + i_w;
        o_vars.a = v_tmp;
        o_vars.b = i_vars.a;
        o_vars.c = rotl30(i_vars.b);
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

`default_nettype wire

// ----- rtl/sha1_hash_engine.sv -----
// SHA-1 digest engine over a byte stream.
// Input beats (s side): tuser = 0 carries one message byte in tdata; tuser = 1
// ends the message and starts padding. Output beats (m side) carry the five
// digest words, word 0 first, with the word index in tuser and tlast on word 4.
// A data byte is taken whenever the block is idle. The byte that completes a 64-byte
// block is followed by the rounds on the single round unit and then an add into
// the chaining words, with tready low throughout.
// An end beat feeds the padding bytes through the same byte path, one per
// cycle (64 - n mod 64 bytes, or that plus 64 when n mod 64 >= 56), runs the
// rounds and the add for each compressed block, then presents the digest
// words one per cycle while the receiver is ready. Each 64 data bytes are
// followed by the round loop, one round per cycle, before the next byte is
// taken. Input is not accepted while padding, compressing or emitting.
// A stalled receiver holds the current digest word; nothing advances until
// it is taken. After word 4 the chaining words and byte count return to
// their initial values. Reset (synchronous, active low) does the same and
// leaves the block idle and ready.
`default_nettype none

module sha1_hash_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_tuser,   // [2:0] word_index
    output logic             o_m_tlast
);
    import sha1he_pkg::*;

    t_state                r_state, n_state;
    logic [BLK_BITS-1:0]   r_blk, n_blk;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [5:0]            r_pos, n_pos;
    logic [6:0]            r_rnd, n_rnd;
    logic [2:0]            r_idx, n_idx;
    logic                  r_first, n_first;
    logic                  r_spill, n_spill;
    logic                  r_final, n_final;
    t_vars                 r_vars, n_vars;
    logic [31:0]           r_h [5];
    logic [31:0]           n_h [5];

    t_vars                 w_rvars;
    t_vars                 w_hvars;
    logic [31:0]           w_sched;
    logic [63:0]           w_len;
    logic [7:0]            w_pad;
    logic                  w_spill;

    sha1he_round u_round (
        .i_vars (r_vars),
        .i_w    (r_blk[511:480]),
        .i_rnd  (r_rnd),
        .o_vars (w_rvars)
    );

    assign w_hvars = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};

    // next schedule word from w[t+13], w[t+8], w[t+2], w[t]
    assign w_sched = rotl1(r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480]);

    assign w_len   = {r_cnt, 3'b000} << {r_pos[2:0], 3'b000};
    assign w_spill = r_spill | (r_first & (&r_pos[5:3]));
    assign w_pad   = r_first ? PAD_BYTE :
                     ((&r_pos[5:3]) && !r_spill) ? w_len[63:56] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_first <= 1'b0;
            r_spill <= 1'b0;
            r_final <= 1'b0;
            for (int i = 0; i < 5; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_spill <= n_spill;
            r_final <= n_final;
            for (int i = 0; i < 5; i++) r_h[i] <= n_h[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_vars <= n_vars;
    end

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        n_first = r_first;
        n_spill = r_spill;
        n_final = r_final;
        n_vars  = r_vars;
        for (int i = 0; i < 5; i++) n_h[i] = r_h[i];
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid) begin
                    if (!i_s_tuser) begin
                        n_blk = {r_blk[BLK_BITS-9:0], i_s_tdata};
                        n_cnt = r_cnt + 1'b1;
                        n_pos = r_pos + 1'b1;
                        if (&r_pos) begin
                            n_state = ST_ROUND;
                            n_vars  = w_hvars;
                            n_rnd   = '0;
                            n_final = 1'b0;
                        end
                    end else begin
                        n_state = ST_PAD;
                        n_first = 1'b1;
                        n_spill = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                // 0x80, zeros, then the big-endian bit length in the last block
                n_blk   = {r_blk[BLK_BITS-9:0], w_pad};
                n_pos   = r_pos + 1'b1;
                n_first = 1'b0;
                n_spill = w_spill;
                if (&r_pos) begin
                    n_state = ST_ROUND;
                    n_vars  = w_hvars;
                    n_rnd   = '0;
                    n_final = !w_spill;
                end
            end
            ST_ROUND: begin
                n_vars = w_rvars;
                n_blk  = {r_blk[BLK_BITS-33:0], w_sched};
                n_rnd  = r_rnd + 1'b1;
                if (r_rnd == RND_LAST) n_state = ST_ADD;
            end
            ST_ADD: begin
                n_h[0] = r_h[0] + r_vars.a;
                n_h[1] = r_h[1] + r_vars.b;
                n_h[2] = r_h[2] + r_vars.c;
                n_h[3] = r_h[3] + r_vars.d;
                n_h[4] = r_h[4] + r_vars.e;
                if (r_final) begin
                    n_state = ST_OUT;
                    n_idx   = '0;
                end else if (r_spill) begin
                    n_state = ST_PAD;
                    n_spill = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd4) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_final = 1'b0;
                        for (int i = 0; i < 5; i++) n_h[i] = H_INIT[i];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tdata = r_h[r_idx];
    assign o_m_tuser = r_idx;
    assign o_m_tlast = (r_idx == 3'd4);

endmodule

`default_nettype wire

// ----- test/tb_sha1_hash_engine.sv -----
`timescale 1ns / 100ps

module tb_sha1_hash_engine;

    localparam int ITEM_TARGET  = 310;
    localparam int MIN_MESSAGES = 5;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;
    localparam logic [7:0]  MSG_PAD = 8'h80;
    localparam int          LEN_OFFSET = 56;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    logic [63:0] msg_bytes;

    t_digest_beat digest_q [$];

    bit steady = 1'b0;
    int items_sent = 0;
    int messages_sent = 0;
    int words_checked = 0;
    int fail_count = 0;
    int cycle_count = 0;

    sha1_hash_engine dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] data_byte
        .i_s_tuser  (s_tuser),   // [0] req_type
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [31:0] digest_word
        .o_m_tuser  (m_tuser),   // [2:0] word_index
        .o_m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic void restore_chain();
        chain[0] = IV_A;
        chain[1] = IV_B;
        chain[2] = IV_C;
        chain[3] = IV_D;
        chain[4] = IV_E;
        msg_bytes = '0;
    endfunction

    function automatic void hash_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16)
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                  w[(r + 2) % 16] ^ w[r % 16], 1);
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void predict_beat(input t_req_kind kind, input logic [7:0] data);
        int pos;
        logic [63:0] bit_len;
        t_digest_beat beat;
        pos = int'(msg_bytes[5:0]);
        if (kind == REQ_DATA) begin
            blk[pos] = data;
            msg_bytes += 1;
            if (msg_bytes[5:0] == 6'd0)
                hash_block();
        end else begin
            bit_len = msg_bytes << 3;
            blk[pos] = MSG_PAD;
            pos++;
            // no room left for the length: spill into a second block
            if (pos > LEN_OFFSET) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                hash_block();
                pos = 0;
            end
            while (pos < LEN_OFFSET) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
            hash_block();
            for (int i = 0; i < 5; i++) begin
                beat.word = chain[i];
                beat.idx  = 3'(i);
                beat.last = (i == 4);
                digest_q = {digest_q, beat};
            end
            restore_chain();
        end
    endfunction

    // Called at a rising edge; leaves tvalid high after the beat is taken.
    task automatic send_beat(input t_req_kind kind, input logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beat(kind, data);
        items_sent++;
        if (kind == REQ_END)
            messages_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(REQ_DATA, 8'($urandom_range(0, 255)));
        // payload of an end beat is ignored; keep it random
        send_beat(REQ_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_empty_message();
        send_beat(REQ_END, 8'h00);
        send_beat(REQ_END, 8'hFF);
    endtask

    task automatic test_short_text();
        send_beat(REQ_DATA, 8'h61);
        send_beat(REQ_DATA, 8'h62);
        send_beat(REQ_DATA, 8'h63);
        send_beat(REQ_END, 8'h00);
    endtask

    task automatic test_byte_extremes();
        send_beat(REQ_DATA, 8'h00);
        send_beat(REQ_DATA, 8'hFF);
        send_beat(REQ_DATA, 8'h01);
        send_beat(REQ_DATA, 8'h80);
        send_beat(REQ_DATA, 8'h7F);
        send_beat(REQ_DATA, 8'hFE);
        send_beat(REQ_END, 8'hFF);
    endtask

    // full rate on both sides across a full block and a short tail
    task automatic test_back_to_back();
        steady = 1'b1;
        send_message(64);
        send_message(5);
        steady = 1'b0;
    endtask

    task automatic test_random_messages();
        int len;
        int done;
        done = 0;
        while (items_sent < ITEM_TARGET || done < MIN_MESSAGES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 20);
                // 55 and 64 fit one final block, 56 and 63 need two
                4, 5, 6: len = 55 + $urandom_range(0, 1) + 8 * $urandom_range(0, 1);
                7: len = 0;
                8: len = $urandom_range(57, 70);
                default: len = 119 + $urandom_range(0, 1) + 8 * $urandom_range(0, 1);
            endcase
            send_message(len);
            done++;
        end
    endtask

    always @(posedge clk) begin
        t_digest_beat exp_beat;
        if (rst_n && m_tvalid && m_tready) begin
            words_checked++;
            if (digest_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected digest word %h idx %0d last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                exp_beat = digest_q.pop_front();
                if (m_tdata !== exp_beat.word || m_tuser !== exp_beat.idx ||
                        m_tlast !== exp_beat.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"digest mismatch: exp %h idx %0d last %b, ",
                                  "got %h idx %0d last %b"},
                                 exp_beat.word, exp_beat.idx, exp_beat.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     digest_q.size());
            $display("FAIL sha1_hash_engine");
            $finish;
        end
    end

    initial begin
        restore_chain();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_short_text();
        test_byte_extremes();
        test_back_to_back();
        test_random_messages();

        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d input beats, %0d digest words checked.",
                 messages_sent, items_sent, words_checked);
        $display("Lengths covered empty, short, one- and two-block padding and multi-block.");
        if (fail_count == 0) begin
            $display("PASS sha1_hash_engine");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAIL sha1_hash_engine");
        end
        $finish;
    end

endmodule
